// File: src/twva_pkg.sv
package twva_pkg;

    // Fixed field widths and counts
    localparam int CHANNELS   = 3;
    localparam int STEP_BITS  = 16;
    localparam int WLEN_BITS  = 22;
    // Window total holds up to one full window plus one new step
    localparam int TOTAL_BITS = WLEN_BITS + 1;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(1000);
    localparam logic [1:0]           CH_LAST    = 2'(CHANNELS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FULL_RD,
        ST_FULL_DROP,
        ST_APPEND,
        ST_CHECK,
        ST_WIN_DROP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } twva_state_t;

    // Control strobes from the sequencer to the datapath
    typedef struct packed {
        logic in_ready;
        logic ram_re;
        logic ram_we;
        logic drop;
        logic append;
        logic div_start;
        logic out_load;
    } twva_ctl_t;

endpackage

// File: src/time_window_vector_average.sv
// Processing: from input transfer to result, an item passes through an eviction when the ring
// is full, the append, one eviction per entry that falls out of the window, and a division per
// channel; an emptied window skips the divisions. Each eviction is a read of
// the oldest ring slot followed by its update; the three means share one bit-serial divider.
// The block takes one item at a time; the next item waits for the result.
// Reset (aresetn low, synchronous) empties the window and sets window_length to 1000.
module time_window_vector_average
    import twva_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration
    input  logic                 cfg_wr_en,
    input  logic [WLEN_BITS-1:0] cfg_wr_data,
    // Input channel
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // sample_a, sample_b, sample_c, time_step, zero pad
    input  logic [((3*SAMPLE_BITS+STEP_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Result channel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // mean_a, mean_b, mean_c, entry_count, zero pad
    output logic [((3*SAMPLE_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
    // window_empty
    output logic                 m_axis_tuser
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = SAMPLE_BITS + AW;
    localparam int RAM_W = CHANNELS * SAMPLE_BITS + STEP_BITS;
    localparam int OUT_W = ((3*SAMPLE_BITS+CW+7)/8)*8;

    twva_state_t state_reg, state_next;
    twva_ctl_t   ctl;

    logic [WLEN_BITS-1:0]         wlen_reg;
    logic [RAM_W-1:0]             in_reg;
    logic [AW-1:0]                oldest_reg;
    logic [CW-1:0]                count_reg;
    logic [TOTAL_BITS-1:0]        total_reg;
    logic signed [SW-1:0]         sum_reg [CHANNELS];
    logic [1:0]                   ch_reg;
    logic signed [SAMPLE_BITS-1:0] mean_reg [CHANNELS];

    logic                         m_valid_reg;
    logic [3*SAMPLE_BITS+CW-1:0]  m_data_reg;
    logic                         m_empty_reg;

    logic [RAM_W-1:0]             rd_data;
    logic [AW:0]                  slot_sum;
    logic [AW-1:0]                wr_slot;
    logic                         ring_full;
    logic                         evict;
    logic                         out_free;
    logic signed [SW-1:0]         div_quot;
    logic                         div_done;

    assign ring_full = (count_reg == CW'(DEPTH));
    assign evict     = (count_reg != '0) && (total_reg > TOTAL_BITS'(wlen_reg));
    assign out_free  = !m_valid_reg || m_axis_tready;

    // Ring slot after the newest entry
    always_comb begin
        slot_sum = {1'b0, oldest_reg} + (AW+1)'(count_reg);
        if (slot_sum >= (AW+1)'(DEPTH)) begin
            slot_sum = slot_sum - (AW+1)'(DEPTH);
        end
        wr_slot = slot_sum[AW-1:0];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ring_full ? ST_FULL_RD : ST_APPEND;
                end
            end
            ST_FULL_RD:   state_next = ST_FULL_DROP;
            ST_FULL_DROP: state_next = ST_APPEND;
            ST_APPEND:    state_next = ST_CHECK;
            ST_CHECK: begin
                if (evict) begin
                    state_next = ST_WIN_DROP;
                end else if (count_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DIV_START;
                end
            end
            ST_WIN_DROP:  state_next = ST_CHECK;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (ch_reg == CH_LAST) ? ST_OUT : ST_DIV_START;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control strobes
    always_comb begin
        ctl = '0;
        case (state_reg)
            ST_IDLE:      ctl.in_ready  = 1'b1;
            ST_FULL_RD:   ctl.ram_re    = 1'b1;
            ST_FULL_DROP: ctl.drop      = 1'b1;
            ST_APPEND: begin
                ctl.ram_we = 1'b1;
                ctl.append = 1'b1;
            end
            ST_CHECK:     ctl.ram_re    = evict;
            ST_WIN_DROP:  ctl.drop      = 1'b1;
            ST_DIV_START: ctl.div_start = 1'b1;
            ST_DIV_WAIT:  ctl = '0;
            ST_OUT:       ctl.out_load  = out_free;
            default:      ctl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Window length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= WLEN_RESET;
        end else if (cfg_wr_en) begin
            wlen_reg <= cfg_wr_data;
        end
    end

    // Hold the accepted item
    always_ff @(posedge aclk) begin
        if (ctl.in_ready && s_axis_tvalid) begin
            in_reg <= s_axis_tdata[RAM_W-1:0];
        end
    end

    // Ring sample store and step store share one word
    twva_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctl.ram_we),
        .waddr (wr_slot),
        .wdata (in_reg),
        .re    (ctl.ram_re),
        .raddr (oldest_reg),
        .rdata (rd_data)
    );

    // Window bookkeeping: drop the oldest entry or append the new one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= '0;
            end
        end else if (ctl.drop) begin
            oldest_reg <= (oldest_reg == AW'(DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
            count_reg  <= count_reg - 1'b1;
            total_reg  <= total_reg - TOTAL_BITS'(rd_data[RAM_W-1 -: STEP_BITS]);
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= sum_reg[c]
                    - SW'($signed(rd_data[c*SAMPLE_BITS +: SAMPLE_BITS]));
            end
        end else if (ctl.append) begin
            count_reg <= count_reg + 1'b1;
            total_reg <= total_reg + TOTAL_BITS'(in_reg[RAM_W-1 -: STEP_BITS]);
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= sum_reg[c]
                    + SW'($signed(in_reg[c*SAMPLE_BITS +: SAMPLE_BITS]));
            end
        end
    end

    // Shared divider, one channel after another
    twva_div #(
        .NUM_BITS (SW),
        .DEN_BITS (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.div_start),
        .dividend (sum_reg[ch_reg]),
        .divisor  (count_reg),
        .quotient (div_quot),
        .done     (div_done)
    );

    // Advance the channel index and collect the means
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg <= '0;
        end else if (ctl.in_ready) begin
            ch_reg <= '0;
        end else if (state_reg == ST_DIV_WAIT && div_done) begin
            ch_reg <= ch_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV_WAIT && div_done) begin
            mean_reg[ch_reg] <= div_quot[SAMPLE_BITS-1:0];
        end
    end

    // Result register: load on completion, clear when the transfer is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            if (count_reg == '0) begin
                m_data_reg  <= '0;
                m_empty_reg <= 1'b1;
            end else begin
                m_data_reg  <= {count_reg, mean_reg[2], mean_reg[1], mean_reg[0]};
                m_empty_reg <= 1'b0;
            end
        end
    end

    assign s_axis_tready = ctl.in_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'(m_data_reg);
    assign m_axis_tuser  = m_empty_reg;

endmodule

// File: src/twva_ram.sv
module twva_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/twva_div.sv
module twva_div #(
    parameter int NUM_BITS = 22,
    parameter int DEN_BITS = 7
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0]        divisor,
    output logic signed [NUM_BITS-1:0] quotient,
    output logic                       done
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] mag_reg;
    logic [NUM_BITS-1:0] mag_next;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] rem_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                neg_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic [NUM_BITS-1:0] abs_in;

    // Magnitude of the dividend; the most negative value maps to its own bits
    assign abs_in = dividend[NUM_BITS-1] ? NUM_BITS'(-dividend) : NUM_BITS'(dividend);

    // One restoring step: shift in the next bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, mag_reg[NUM_BITS-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            rem_next = diff[DEN_BITS-1:0];
            mag_next = {mag_reg[NUM_BITS-2:0], 1'b1};
        end else begin
            rem_next = trial[DEN_BITS-1:0];
            mag_next = {mag_reg[NUM_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand registers
    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= abs_in;
            rem_reg <= '0;
            neg_reg <= dividend[NUM_BITS-1];
        end else if (busy_reg) begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    // Restore the sign: truncation toward zero
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
    assign done     = done_reg;

endmodule
